### hw/rtl/assert_macros.svh
// Assertion helpers shared by the message FIFO modules.
// Each macro expects clk and rst_n in scope and is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant that holds at every clock edge.
`define IDMF_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define IDMF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define IDMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/idmf_pkg.sv
// ----------------------------------------------------------------------------
// idmf_pkg
// Shared constants, codes and controller/datapath interface types of the
// message FIFO with in-place replacement by ID.
// ----------------------------------------------------------------------------
`default_nettype none

package idmf_pkg;

    localparam int CAPACITY  = 64;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int ID_W      = 29;
    localparam int TIME_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int NUM_BYTES = 8;
    localparam int BODY_W    = TIME_W + NUM_BYTES * BYTE_W;

    // Any code other than push and add-or-replace is a pop.
    typedef enum logic [1:0] {
        KIND_PUSH = 2'd0,
        KIND_ADD  = 2'd1,
        KIND_POP  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_APPENDED = 3'd0,
        ST_REPLACED = 3'd1,
        ST_DROPPED  = 3'd2,
        ST_POPPED   = 3'd3,
        ST_EMPTY    = 3'd4
    } result_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic head_rd;
        logic scan_en;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic is_add;
        logic scan_done;
        logic out_free;
    } dp_stat_t;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        if (idx == IDX_W'(CAPACITY - 1))
        begin
            return '0;
        end
        return idx + IDX_W'(1);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/id_dedup_message_fifo.sv
// ----------------------------------------------------------------------------
// id_dedup_message_fifo: 64-entry message FIFO with replace-by-ID
// One transaction at a time; next accept follows commit; output stalls add cycles.
// Push and pop: accept, then commit from S_COMMIT once the output register is free;
// the result is registered at commit. Add-or-replace: one-entry-per-cycle ID scan
// from the oldest entry, stopping at the first ID match, then commit as above.
// Reset clears pointers, fill count and output valid; entry RAMs are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module id_dedup_message_fifo (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                kind,
    input  logic [idmf_pkg::ID_W-1:0] msg_id,
    input  logic [31:0]               time_ms,
    input  logic [7:0]                in_byte0,
    input  logic [7:0]                in_byte1,
    input  logic [7:0]                in_byte2,
    input  logic [7:0]                in_byte3,
    input  logic [7:0]                in_byte4,
    input  logic [7:0]                in_byte5,
    input  logic [7:0]                in_byte6,
    input  logic [7:0]                in_byte7,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [2:0]                status,
    output logic [idmf_pkg::ID_W-1:0] out_id,
    output logic [31:0]               out_time,
    output logic [7:0]                out_byte0,
    output logic [7:0]                out_byte1,
    output logic [7:0]                out_byte2,
    output logic [7:0]                out_byte3,
    output logic [7:0]                out_byte4,
    output logic [7:0]                out_byte5,
    output logic [7:0]                out_byte6,
    output logic [7:0]                out_byte7
);

    import idmf_pkg::*;

    dp_cmd_t           dp_cmd;
    dp_stat_t          dp_stat;
    logic [BODY_W-1:0] in_body;
    logic [BODY_W-1:0] out_body;

    assign in_body = {time_ms, in_byte7, in_byte6, in_byte5, in_byte4,
                      in_byte3, in_byte2, in_byte1, in_byte0};

    assign {out_time, out_byte7, out_byte6, out_byte5, out_byte4,
            out_byte3, out_byte2, out_byte1, out_byte0} = out_body;

    idmf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .dp_stat  (dp_stat),
        .dp_cmd   (dp_cmd)
    );

    idmf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat),
        .kind      (kind),
        .msg_id    (msg_id),
        .in_body   (in_body),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (status),
        .out_id    (out_id),
        .out_body  (out_body)
    );

endmodule

`default_nettype wire

### hw/rtl/idmf_ram.sv
// ----------------------------------------------------------------------------
// idmf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module idmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/idmf_ctrl.sv
// ----------------------------------------------------------------------------
// idmf_ctrl
// Sequencer: accepts one transaction, runs the ID scan for add-or-replace,
// and commits the result once the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module idmf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  idmf_pkg::dp_stat_t dp_stat,
    output idmf_pkg::dp_cmd_t  dp_cmd
);

    import idmf_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready       = 1'b1;
                // keep the head entry on the read port for a pop
                dp_cmd.head_rd = 1'b1;
                if (in_valid)
                begin
                    dp_cmd.accept = 1'b1;
                    state_next    = dp_stat.is_add ? S_SCAN : S_COMMIT;
                end
            end
            S_SCAN:
            begin
                dp_cmd.scan_en = 1'b1;
                if (dp_stat.scan_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (dp_stat.out_free)
                begin
                    dp_cmd.commit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `IDMF_ASSERT_NEXT(a_scan_exit, state_reg == S_SCAN && dp_stat.scan_done, state_reg == S_COMMIT, "scan end did not lead to commit")

endmodule

`default_nettype wire

### hw/rtl/idmf_dp.sv
// ----------------------------------------------------------------------------
// idmf_dp
// Entry storage, ring pointers, sequential ID scan and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module idmf_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  idmf_pkg::dp_cmd_t             dp_cmd,
    output idmf_pkg::dp_stat_t            dp_stat,
    input  logic [1:0]                    kind,
    input  logic [idmf_pkg::ID_W-1:0]     msg_id,
    input  logic [idmf_pkg::BODY_W-1:0]   in_body,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    result,
    output logic [idmf_pkg::ID_W-1:0]     out_id,
    output logic [idmf_pkg::BODY_W-1:0]   out_body
);

    import idmf_pkg::*;

    // control state
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic             pend_reg, pend_next;
    logic             hit_reg, hit_next;
    logic             out_valid_reg, out_valid_next;

    // payload
    logic [1:0]        kind_reg;
    logic [ID_W-1:0]   id_reg;
    logic [BODY_W-1:0] body_reg;
    logic [IDX_W-1:0]  pend_idx_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    result_t           result_reg, result_next;
    logic [ID_W-1:0]   out_id_reg;
    logic [BODY_W-1:0] out_body_reg;

    // memory ports
    logic              id_we, body_we, rd_en, pop_out;
    logic [IDX_W-1:0]  wr_addr, rd_addr;
    logic [ID_W-1:0]   id_rdata;
    logic [BODY_W-1:0] body_rdata;

    logic issue, match;

    assign issue = dp_cmd.scan_en && (scan_cnt_reg != fill_reg);
    assign match = dp_cmd.scan_en && pend_reg && (id_rdata == id_reg);

    assign dp_stat.is_add    = (kind == KIND_ADD);
    assign dp_stat.scan_done = match || ((scan_cnt_reg == fill_reg) && !pend_reg);
    assign dp_stat.out_free  = !out_valid_reg || out_ready;

    assign rd_en   = dp_cmd.head_rd || issue;
    assign rd_addr = dp_cmd.scan_en ? scan_idx_reg : head_reg;

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        scan_idx_next  = scan_idx_reg;
        scan_cnt_next  = scan_cnt_reg;
        pend_next      = pend_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        id_we          = 1'b0;
        body_we        = 1'b0;
        wr_addr        = tail_reg;
        pop_out        = 1'b0;
        result_next    = ST_APPENDED;

        if (dp_cmd.accept)
        begin
            scan_idx_next = head_reg;
            scan_cnt_next = '0;
            pend_next     = 1'b0;
            hit_next      = 1'b0;
        end
        else if (dp_cmd.scan_en)
        begin
            // compare the entry read last cycle, issue the next read
            pend_next = issue;
            if (issue)
            begin
                scan_idx_next = next_idx(scan_idx_reg);
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
            end
            if (match)
            begin
                hit_next = 1'b1;
            end
        end

        if (dp_cmd.commit)
        begin
            out_valid_next = 1'b1;
            case (kind_reg) inside
                KIND_PUSH, KIND_ADD:
                begin
                    if (hit_reg)
                    begin
                        body_we     = 1'b1;
                        wr_addr     = hit_idx_reg;
                        result_next = ST_REPLACED;
                    end
                    else if (fill_reg == CNT_W'(CAPACITY))
                    begin
                        result_next = ST_DROPPED;
                    end
                    else
                    begin
                        id_we     = 1'b1;
                        body_we   = 1'b1;
                        tail_next = next_idx(tail_reg);
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                    if (fill_reg == '0)
                    begin
                        result_next = ST_EMPTY;
                    end
                    else
                    begin
                        result_next = ST_POPPED;
                        pop_out     = 1'b1;
                        head_next   = next_idx(head_reg);
                        fill_next   = fill_reg - CNT_W'(1);
                    end
                end
            endcase
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            scan_idx_reg  <= '0;
            scan_cnt_reg  <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            scan_idx_reg  <= scan_idx_next;
            scan_cnt_reg  <= scan_cnt_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.accept)
        begin
            kind_reg <= kind;
            id_reg   <= msg_id;
            body_reg <= in_body;
        end
        if (dp_cmd.scan_en)
        begin
            pend_idx_reg <= scan_idx_reg;
            if (match)
            begin
                hit_idx_reg <= pend_idx_reg;
            end
        end
        if (dp_cmd.commit)
        begin
            result_reg   <= result_next;
            out_id_reg   <= pop_out ? id_rdata : '0;
            out_body_reg <= pop_out ? body_rdata : '0;
        end
    end

    idmf_ram #(
        .WIDTH (ID_W),
        .DEPTH (CAPACITY)
    ) u_id_ram (
        .clk   (clk),
        .we    (id_we),
        .waddr (wr_addr),
        .wdata (id_reg),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (id_rdata)
    );

    idmf_ram #(
        .WIDTH (BODY_W),
        .DEPTH (CAPACITY)
    ) u_body_ram (
        .clk   (clk),
        .we    (body_we),
        .waddr (wr_addr),
        .wdata (body_reg),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (body_rdata)
    );

    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign out_id    = out_id_reg;
    assign out_body  = out_body_reg;

    `IDMF_ASSERT(a_fill_bound, fill_reg <= CNT_W'(CAPACITY), "fill count above capacity")
    `IDMF_ASSERT_IMPL(a_empty_ptrs, fill_reg == '0, head_reg == tail_reg, "empty with head != tail")
    `IDMF_ASSERT_IMPL(a_commit_free, dp_cmd.commit, !out_valid_reg || out_ready, "commit overwrote result")
    `IDMF_ASSERT_IMPL(a_zero_nonpop, out_valid_reg && result_reg != ST_POPPED, out_id_reg == '0 && out_body_reg == '0, "non-pop result carries data")

endmodule

`default_nettype wire
